// ===== hw/rtl/dasf_pkg.sv =====
// Shared types and constants for the dual audio sample FIFO.
package dasf_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int DROP_W    = 32;
	localparam int LEVEL_W   = 8;
	localparam int OP_W      = 3;
	localparam int COUNT_W   = 7;
	localparam logic [COUNT_W-1:0] MAX_BURST = 7'd64;

	localparam logic [OP_W-1:0] OP_PUSH_IN   = 3'd0;
	localparam logic [OP_W-1:0] OP_POP_IN    = 3'd1;
	localparam logic [OP_W-1:0] OP_PUSH_OUT  = 3'd2;
	localparam logic [OP_W-1:0] OP_BURST_OUT = 3'd3;
	localparam logic [OP_W-1:0] OP_QUERY     = 3'd4;
	localparam logic [OP_W-1:0] OP_RESET_ALL = 3'd5;
	localparam logic [OP_W-1:0] OP_RESET_OUT = 3'd6;

	// Command from the sequencer to one ring.
	typedef struct packed {
		logic                push;
		logic                pop;
		logic                clr;
		logic [SAMPLE_W-1:0] wdata;
	} ring_cmd_t;

	// Fill status of one ring, taken before the command of this cycle.
	typedef struct packed {
		logic full;
		logic empty;
	} ring_stat_t;

endpackage

// ===== hw/rtl/dasf_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module dasf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/dasf_ring.sv =====
// One circular sample ring: pointers, drop counter and the sample memory.
module dasf_ring #(
	parameter int NUM_SLOTS = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dasf_pkg::ring_cmd_t           cmd,
	output dasf_pkg::ring_stat_t          stat,
	output logic [$clog2(NUM_SLOTS)-1:0]  occ,
	output logic [dasf_pkg::DROP_W-1:0]   drops,
	output logic [dasf_pkg::SAMPLE_W-1:0] rdata
);

	localparam int PW = $clog2(NUM_SLOTS);
	localparam logic [PW-1:0] LAST_SLOT = PW'(NUM_SLOTS - 1);
	localparam logic [PW:0]   SIZE_V    = (PW + 1)'(NUM_SLOTS);

	logic [PW-1:0] rd_q;
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_nxt;
	logic [PW-1:0] wr_nxt;
	logic [PW:0]   wrap_occ;
	logic          do_write;
	logic          do_read;

	assign rd_nxt = (rd_q == LAST_SLOT) ? '0 : rd_q + 1'b1;
	assign wr_nxt = (wr_q == LAST_SLOT) ? '0 : wr_q + 1'b1;

	// One slot always stays empty, so full means the writer would meet the reader.
	assign stat.full  = (wr_nxt == rd_q);
	assign stat.empty = (wr_q == rd_q);

	assign wrap_occ = SIZE_V - {1'b0, rd_q} + {1'b0, wr_q};
	assign occ      = (wr_q >= rd_q) ? (wr_q - rd_q) : wrap_occ[PW-1:0];

	assign do_write = cmd.push && !stat.full;
	assign do_read  = cmd.pop && !stat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= '0;
			wr_q  <= '0;
			drops <= '0;
		end else if (cmd.clr) begin
			rd_q  <= '0;
			wr_q  <= '0;
			drops <= '0;
		end else begin
			if (do_write) begin
				wr_q <= wr_nxt;
			end else if (cmd.push) begin
				drops <= drops + 1'b1;
			end
			if (do_read) begin
				rd_q <= rd_nxt;
			end
		end
	end

	dasf_ram #(
		.WIDTH (dasf_pkg::SAMPLE_W),
		.DEPTH (NUM_SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (do_write),
		.waddr (wr_q),
		.wdata (cmd.wdata),
		.re    (do_read),
		.raddr (rd_q),
		.rdata (rdata)
	);

endmodule

// ===== hw/rtl/dual_audio_sample_fifo.sv =====
// Top level of the dual audio sample FIFO: request sequencer and result register.
//
// Channel  Dir  Handshake          Payload
// s_*      in   s_tvalid/s_tready  tdata: byte_low, byte_high, sample, pop_count
//                                  tuser: op    tlast: buffer_end
// m_*      out  m_tvalid/m_tready  tdata: popped sample, out_level, in/out drop counts
//                                  tuser: sample_valid, accepted    tlast: last
//
// A single request is accepted in the idle state, accesses its ring in the execute
// state and loads the output register in the result state. A burst pop passes idle
// and execute, then a read and a load state per popped sample (registered read data).
// Reset clears the pointers and drop counters of both rings but not the sample memories.
// A stalled output holds the sequencer in its result or burst load state; a result
// waiting alone in the output register does not block the next request.
module dual_audio_sample_fifo #(
	parameter int NUM_SLOTS = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [7:0] byte_low, [15:8] byte_high, [31:16] sample, [38:32] pop_count, rest zero
	input  logic [39:0] s_tdata,
	// [2:0] op
	input  logic [2:0]  s_tuser,
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [15:0] popped sample, [23:16] out_level, [55:24] in_drop_count,
	// [87:56] out_drop_count
	output logic [87:0] m_tdata,
	// [0] sample_valid, [1] accepted
	output logic [1:0]  m_tuser,
	output logic        m_tlast
);

	localparam int PW = $clog2(NUM_SLOTS);
	localparam int LW = (PW > dasf_pkg::LEVEL_W) ? PW : dasf_pkg::LEVEL_W;
	localparam int CW = (PW > dasf_pkg::COUNT_W) ? PW : dasf_pkg::COUNT_W;

	// Sequencer states.
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_EXEC   = 3'd1;
	localparam logic [2:0] ST_RESULT = 3'd2;
	localparam logic [2:0] ST_BREAD  = 3'd3;
	localparam logic [2:0] ST_BEMIT  = 3'd4;

	logic [2:0] state_q;

	// Latched request fields. The buffer_end mark carries no meaning for the rings.
	logic [dasf_pkg::OP_W-1:0]     op_q;
	logic [7:0]                    blo_q;
	logic [7:0]                    bhi_q;
	logic [dasf_pkg::SAMPLE_W-1:0] smp_q;
	logic [dasf_pkg::COUNT_W-1:0]  want_q;

	// Result bookkeeping set up in the execute cycle.
	logic                          acc_q;
	logic                          valid_q;
	logic                          use_in_q;
	logic                          burst_q;
	logic [PW-1:0]                 lvl_q;
	logic [dasf_pkg::COUNT_W-1:0]  cnt_q;

	dasf_pkg::ring_cmd_t  in_cmd;
	dasf_pkg::ring_cmd_t  out_cmd;
	dasf_pkg::ring_stat_t in_stat;
	dasf_pkg::ring_stat_t out_stat;
	logic [PW-1:0]                 in_occ;
	logic [PW-1:0]                 out_occ;
	logic [dasf_pkg::DROP_W-1:0]   in_drops;
	logic [dasf_pkg::DROP_W-1:0]   out_drops;
	logic [dasf_pkg::SAMPLE_W-1:0] in_rdata;
	logic [dasf_pkg::SAMPLE_W-1:0] out_rdata;

	logic                          slot_free;
	logic                          load;
	logic [dasf_pkg::COUNT_W-1:0]  want_lim;
	logic [dasf_pkg::COUNT_W-1:0]  burst_n;
	logic [PW-1:0]                 lvl_sel;
	logic [LW-1:0]                 lvl_wide;
	logic [dasf_pkg::SAMPLE_W-1:0] smp_res;

	assign s_tready = (state_q == ST_IDLE);

	// The output register accepts a new result when empty or being drained.
	assign slot_free = !m_tvalid || m_tready;
	assign load      = slot_free && ((state_q == ST_RESULT) || (state_q == ST_BEMIT));

	// A burst pops no more than the limit and no more than the ring holds.
	assign want_lim = (want_q > dasf_pkg::MAX_BURST) ? dasf_pkg::MAX_BURST : want_q;
	assign burst_n  = (CW'(want_lim) > CW'(out_occ)) ? dasf_pkg::COUNT_W'(out_occ)
	                                                : want_lim;

	// Ring commands: accesses happen in the execute cycle, burst reads in their own.
	always_comb begin
		in_cmd        = '0;
		out_cmd       = '0;
		in_cmd.wdata  = {bhi_q, blo_q};
		out_cmd.wdata = smp_q;
		if (state_q == ST_EXEC) begin
			unique case (op_q)
				dasf_pkg::OP_PUSH_IN: begin
					in_cmd.push = 1'b1;
				end
				dasf_pkg::OP_POP_IN: begin
					in_cmd.pop = 1'b1;
				end
				dasf_pkg::OP_PUSH_OUT: begin
					out_cmd.push = 1'b1;
				end
				dasf_pkg::OP_RESET_ALL: begin
					in_cmd.clr  = 1'b1;
					out_cmd.clr = 1'b1;
				end
				dasf_pkg::OP_RESET_OUT: begin
					out_cmd.clr = 1'b1;
				end
				default: begin
				end
			endcase
		end else if (state_q == ST_BREAD) begin
			out_cmd.pop = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (op_q == dasf_pkg::OP_BURST_OUT && burst_n != '0) begin
						state_q <= ST_BREAD;
					end else begin
						state_q <= ST_RESULT;
					end
				end
				ST_RESULT: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_BREAD: begin
					state_q <= ST_BEMIT;
				end
				ST_BEMIT: begin
					if (slot_free) begin
						state_q <= (cnt_q == '0) ? ST_IDLE : ST_BREAD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request capture and per-request bookkeeping.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_q   <= s_tuser;
			blo_q  <= s_tdata[7:0];
			bhi_q  <= s_tdata[15:8];
			smp_q  <= s_tdata[31:16];
			want_q <= s_tdata[38:32];
		end
		if (state_q == ST_EXEC) begin
			acc_q    <= 1'b0;
			valid_q  <= 1'b0;
			use_in_q <= 1'b0;
			burst_q  <= 1'b0;
			// Every result of a burst reports the level after the whole burst.
			lvl_q    <= out_occ - PW'(burst_n);
			cnt_q    <= burst_n;
			unique case (op_q)
				dasf_pkg::OP_PUSH_IN: begin
					acc_q <= !in_stat.full;
				end
				dasf_pkg::OP_POP_IN: begin
					valid_q  <= !in_stat.empty;
					use_in_q <= 1'b1;
				end
				dasf_pkg::OP_PUSH_OUT: begin
					acc_q <= !out_stat.full;
				end
				dasf_pkg::OP_BURST_OUT: begin
					valid_q <= (burst_n != '0);
					burst_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
		if (state_q == ST_BREAD) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	assign lvl_sel  = burst_q ? lvl_q : out_occ;
	assign lvl_wide = LW'(lvl_sel);
	assign smp_res  = !valid_q ? '0 : (use_in_q ? in_rdata : out_rdata);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_tdata <= {out_drops, in_drops, lvl_wide[dasf_pkg::LEVEL_W-1:0], smp_res};
			m_tuser <= {acc_q, valid_q};
			m_tlast <= (state_q == ST_RESULT) || (cnt_q == '0);
		end
	end

	dasf_ring #(
		.NUM_SLOTS (NUM_SLOTS)
	) u_in_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (in_cmd),
		.stat   (in_stat),
		.occ    (in_occ),
		.drops  (in_drops),
		.rdata  (in_rdata)
	);

	dasf_ring #(
		.NUM_SLOTS (NUM_SLOTS)
	) u_out_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (out_cmd),
		.stat   (out_stat),
		.occ    (out_occ),
		.drops  (out_drops),
		.rdata  (out_rdata)
	);

	// The inbound occupancy is not reported; its ring is steered by full and empty.
	logic in_occ_unused;
	assign in_occ_unused = ^in_occ ^ s_tlast;

endmodule

// ===== test/dual_audio_sample_fifo_test.sv =====
// Self-checking testbench for the dual audio sample FIFO with stream-side idling and stalls.
module dual_audio_sample_fifo_test;

	import dasf_pkg::*;

	// Op code 7 has no name in the package; the block treats it as a query.
	localparam logic [OP_W-1:0] OP_SPARE = 3'd7;
	localparam int CYCLE_LIMIT = 500000;
	localparam int IDLE_PCT    = 14;
	localparam int MAX_REPORTS = 10;

	// One request as it travels on the slave side.
	typedef struct packed {
		logic [OP_W-1:0]            op;
		logic [7:0]                 byte_low;
		logic [7:0]                 byte_high;
		logic signed [SAMPLE_W-1:0] sample;
		logic [COUNT_W-1:0]         pop_count;
		logic                       buffer_end;
	} fifo_req_t;

	// One reply as it comes back on the master side.
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] smp_out;
		logic                       sample_valid;
		logic                       accepted;
		logic                       last;
		logic [LEVEL_W-1:0]         out_level;
		logic [DROP_W-1:0]          in_drops;
		logic [DROP_W-1:0]          out_drops;
	} fifo_reply_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;
	logic [2:0]  s_tuser = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [87:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	dual_audio_sample_fifo dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	// Requests waiting to be driven, and replies the rings still owe us.
	fifo_req_t   requests_to_send[$];
	fifo_reply_t fifo_replies_due[$];
	fifo_req_t   cur_req = '0;
	logic        req_taken = 1'b0;
	int          n_taken = 0;
	int          errors = 0;
	int          cycle_count = 0;

	// Shadow copy of both rings. The pointers are eight bits wide, so they wrap
	// at the ring size on their own, and one slot always stays empty.
	logic [SAMPLE_W-1:0] in_slots [256];
	logic [SAMPLE_W-1:0] out_slots [256];
	logic [7:0]          in_rd = '0, in_wr = '0, out_rd = '0, out_wr = '0;
	logic [DROP_W-1:0]   in_drops = '0, out_drops = '0;

	// A stretch in the middle of the run, inside the big fill, runs with no idling.
	wire calm = (n_taken >= 150) && (n_taken < 350);

	// Advance the shadow rings by one request and queue the replies it owes.
	task automatic apply_request(input fifo_req_t r);
		fifo_reply_t         rep;
		logic [SAMPLE_W-1:0] popped[$];
		logic [7:0]          nxt;
		int                  want;
		rep = '0;
		case (r.op)
			OP_PUSH_IN: begin
				nxt = in_wr + 8'd1;
				if (nxt == in_rd) begin
					in_drops = in_drops + 1'b1;
				end else begin
					in_slots[in_wr] = {r.byte_high, r.byte_low};
					in_wr = nxt;
					rep.accepted = 1'b1;
				end
			end
			OP_POP_IN: begin
				if (in_rd != in_wr) begin
					rep.smp_out = in_slots[in_rd];
					rep.sample_valid = 1'b1;
					in_rd = in_rd + 8'd1;
				end
			end
			OP_PUSH_OUT: begin
				nxt = out_wr + 8'd1;
				if (nxt == out_rd) begin
					out_drops = out_drops + 1'b1;
				end else begin
					out_slots[out_wr] = r.sample;
					out_wr = nxt;
					rep.accepted = 1'b1;
				end
			end
			OP_BURST_OUT: begin
				// Counts above the burst limit are clipped to it.
				want = (r.pop_count > MAX_BURST) ? int'(MAX_BURST) : int'(r.pop_count);
				while (popped.size() < want && out_rd != out_wr) begin
					popped.push_back(out_slots[out_rd]);
					out_rd = out_rd + 8'd1;
				end
			end
			OP_RESET_ALL: begin
				in_rd = '0;
				in_wr = '0;
				in_drops = '0;
				out_rd = '0;
				out_wr = '0;
				out_drops = '0;
			end
			OP_RESET_OUT: begin
				out_rd = '0;
				out_wr = '0;
				out_drops = '0;
			end
			default: begin
			end
		endcase
		// Level and counters in every reply are those after the whole request.
		rep.out_level = out_wr - out_rd;
		rep.in_drops = in_drops;
		rep.out_drops = out_drops;
		if (popped.size() == 0) begin
			rep.last = 1'b1;
			fifo_replies_due.push_back(rep);
		end else begin
			foreach (popped[k]) begin
				rep.smp_out = popped[k];
				rep.sample_valid = 1'b1;
				rep.last = (k == popped.size() - 1);
				fifo_replies_due.push_back(rep);
			end
		end
	endtask

	// A request of the given op with every other field random. Burst sizes
	// stay mostly in range, with some zero and some above the limit.
	function automatic fifo_req_t rand_req(input logic [OP_W-1:0] op);
		fifo_req_t r;
		int        pick;
		r.op = op;
		r.byte_low = 8'($urandom);
		r.byte_high = 8'($urandom);
		r.sample = 16'($urandom);
		r.buffer_end = 1'($urandom);
		pick = $urandom_range(99);
		if (pick < 8)
			r.pop_count = '0;
		else if (pick < 18)
			r.pop_count = 7'($urandom_range(127, 65));
		else
			r.pop_count = 7'($urandom_range(64, 1));
		return r;
	endfunction

	function automatic logic [OP_W-1:0] rand_op();
		int pick;
		pick = $urandom_range(99);
		if (pick < 20) return OP_PUSH_IN;
		if (pick < 38) return OP_POP_IN;
		if (pick < 60) return OP_PUSH_OUT;
		if (pick < 76) return OP_BURST_OUT;
		if (pick < 84) return OP_QUERY;
		if (pick < 88) return OP_SPARE;
		if (pick < 95) return OP_RESET_OUT;
		return OP_RESET_ALL;
	endfunction

	task automatic add_req(input logic [OP_W-1:0] op);
		requests_to_send.push_back(rand_req(op));
	endtask

	task automatic add_byte_pair(input logic [7:0] lo, input logic [7:0] hi);
		fifo_req_t r;
		r = rand_req(OP_PUSH_IN);
		r.byte_low = lo;
		r.byte_high = hi;
		requests_to_send.push_back(r);
	endtask

	task automatic add_sample(input logic [SAMPLE_W-1:0] s);
		fifo_req_t r;
		r = rand_req(OP_PUSH_OUT);
		r.sample = s;
		requests_to_send.push_back(r);
	endtask

	task automatic add_burst(input logic [COUNT_W-1:0] n);
		fifo_req_t r;
		r = rand_req(OP_BURST_OUT);
		r.pop_count = n;
		requests_to_send.push_back(r);
	endtask

	// Driver: a request stays on the bus until it is taken, then the next one
	// goes out unless this cycle is picked as a gap.
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || req_taken)) begin
			if (requests_to_send.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
				cur_req <= requests_to_send[0];
				s_tdata <= {1'b0, requests_to_send[0].pop_count, requests_to_send[0].sample,
					requests_to_send[0].byte_high, requests_to_send[0].byte_low};
				s_tuser <= requests_to_send[0].op;
				s_tlast <= requests_to_send[0].buffer_end;
				s_tvalid <= 1'b1;
				void'(requests_to_send.pop_front());
			end else begin
				s_tvalid <= 1'b0;
			end
		end
		if (arst_n)
			m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
	end

	// Monitor: checks each reply against the oldest one due, then feeds the
	// shadow rings with the request taken at this edge.
	always @(posedge clk) begin
		fifo_reply_t got;
		fifo_reply_t want;
		got.smp_out = m_tdata[15:0];
		got.sample_valid = m_tuser[0];
		got.accepted = m_tuser[1];
		got.last = m_tlast;
		got.out_level = m_tdata[23:16];
		got.in_drops = m_tdata[55:24];
		got.out_drops = m_tdata[87:56];
		if (arst_n && m_tvalid && m_tready) begin
			if (fifo_replies_due.size() == 0) begin
				if (errors < MAX_REPORTS)
					$display("unexpected reply: sample %0d valid %0b acc %0b last %0b lvl %0d",
						got.smp_out, got.sample_valid, got.accepted, got.last,
						got.out_level);
				errors++;
			end else begin
				want = fifo_replies_due.pop_front();
				if (got !== want) begin
					if (errors < MAX_REPORTS) begin
						$display("reply mismatch: expected sample %0d valid %0b acc %0b last %0b",
							want.smp_out, want.sample_valid, want.accepted, want.last);
						$display("  lvl %0d in_drops %0d out_drops %0d", want.out_level,
							want.in_drops, want.out_drops);
						$display("  got sample %0d valid %0b acc %0b last %0b",
							got.smp_out, got.sample_valid, got.accepted, got.last);
						$display("  lvl %0d in_drops %0d out_drops %0d", got.out_level,
							got.in_drops, got.out_drops);
					end
					errors++;
				end
			end
		end
		req_taken <= arst_n && s_tvalid && s_tready;
		if (arst_n && s_tvalid && s_tready) begin
			apply_request(cur_req);
			n_taken <= n_taken + 1;
		end
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL dual_audio_sample_fifo");
			$finish;
		end
	end

	initial begin
		int pushes_in;
		int pushes_out;

		// Directed part: empty pops, sample extremes, burst edge sizes, and
		// both kinds of reset.
		add_req(OP_RESET_ALL);
		add_req(OP_POP_IN);
		add_burst(7'd5);
		add_byte_pair(8'h00, 8'h00);
		add_byte_pair(8'hFF, 8'h7F);
		add_byte_pair(8'h00, 8'h80);
		add_byte_pair(8'hFF, 8'hFF);
		repeat (5) add_req(OP_POP_IN);
		add_sample(16'h7FFF);
		add_sample(16'h8000);
		add_sample(16'hFFFF);
		add_sample(16'h0000);
		add_burst(7'd0);
		add_burst(7'd1);
		add_burst(7'd127);
		add_sample(16'h1234);
		add_req(OP_QUERY);
		add_req(OP_SPARE);
		add_req(OP_RESET_OUT);
		add_req(OP_QUERY);
		add_req(OP_RESET_ALL);

		// Random mix before the fill.
		repeat (30) add_req(rand_op());

		// Fill the outbound ring past full so it drops a few pushes, with a
		// share of inbound pushes and the odd query mixed in.
		add_req(OP_RESET_ALL);
		pushes_in = 0;
		pushes_out = 0;
		while (pushes_in < 80 || pushes_out < 258) begin
			if ($urandom_range(99) < 5) begin
				add_req($urandom_range(1) ? OP_QUERY : OP_SPARE);
			end else if ((pushes_in < 80 && $urandom_range(3) == 0) || pushes_out >= 258) begin
				add_req(OP_PUSH_IN);
				pushes_in++;
			end else begin
				add_req(OP_PUSH_OUT);
				pushes_out++;
			end
		end

		// Random mix from a full outbound ring: long bursts, wraparound, resets.
		repeat (60) add_req(rand_op());

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (requests_to_send.size() > 0 || s_tvalid || fifo_replies_due.size() > 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0 && fifo_replies_due.size() == 0)
			$display("PASS dual_audio_sample_fifo");
		else
			$display("FAIL dual_audio_sample_fifo");
		$finish;
	end

endmodule
